### design/cce_pkg.sv
// Shared constants and the block-graphics plot function for the character-cell editor.
package cce_pkg;

  localparam int COLUMNS_DEF = 32;
  localparam int ROWS_DEF    = 24;

  localparam logic [2:0] OP_PEEK   = 3'd0;
  localparam logic [2:0] OP_POKE   = 3'd1;
  localparam logic [2:0] OP_PLOT   = 3'd2;
  localparam logic [2:0] OP_INSERT = 3'd3;
  localparam logic [2:0] OP_DELETE = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;

  localparam logic [1:0] PLOT_CLR = 2'd0;
  localparam logic [1:0] PLOT_SET = 2'd1;

  localparam logic [7:0] GFX_FOLD  = 8'h8f;
  localparam logic [7:0] LOW7_MASK = 8'd127;
  localparam logic [7:0] GFX_MAX   = 8'd7;
  localparam logic [7:0] GFX_FILL  = 8'd128;

  // bit_sel is one-hot over the 2x2 quarter-cell block
  function automatic logic [7:0] plot_code(input logic [7:0] code,
                                           input logic [3:0] bit_sel,
                                           input logic [1:0] mode);
    logic [7:0] c;
    logic [7:0] b;
    c = code;
    b = {4'd0, bit_sel};
    if ((c & LOW7_MASK) > GFX_MAX) c = 8'd0;
    if (c > LOW7_MASK) c = c ^ GFX_FOLD;
    case (mode)
      PLOT_CLR: c = c & ~b;
      PLOT_SET: c = c | b;
      default:  c = c ^ b;
    endcase
    if (c > GFX_MAX) c = c ^ GFX_FOLD;
    return c;
  endfunction

endpackage

### design/cce_store.sv
// Single-port character store with registered read data.
module cce_store #(
  parameter int DEPTH  = 768,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              re,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [7:0]        wdata,
  output logic [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### design/char_cell_display_editor.sv
// Character-cell display editor: top level with command sequencer.
// Usage: one command word enters on the input channel (in_valid/in_stall),
// and exactly one result word (read_value) leaves on the output channel
// (out_valid/out_stall) for each command, in order.
// All work goes through one single-port store of COLUMNS*ROWS cells with a
// registered read port, stepped by a small sequencer; in_stall is high
// while a command is in progress.
// Steps from accept to result register:
//   peek, plot: read the cell, then load the result (plot also writes it back);
//   poke: write the cell; out-of-range or unused opcode: straight to the result;
//   insert/delete: a read and a write per cell moved, then the fill write;
//   clear: one cell written per cycle, over all COLUMNS*ROWS cells.
// A new command is accepted once in_stall drops, in the cycle after the result is loaded.
// Reset: a clearing pass over the COLUMNS*ROWS cells (768 by default) zeroes the
// store; in_stall stays high until it finishes, and no result is produced.
// A result waiting under out_stall does not block the next command from
// being accepted; the sequencer only holds when it has a new result and
// the output register is still occupied.
module char_cell_display_editor #(
  parameter int COLUMNS = cce_pkg::COLUMNS_DEF,
  parameter int ROWS    = cce_pkg::ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] opcode,
  input  logic [5:0] col,
  input  logic [5:0] row,
  input  logic [7:0] write_value,
  input  logic [1:0] plot_mode,
  input  logic       graphics_fill,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_value
);

  import cce_pkg::*;

  localparam int DEPTH  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int KW     = $clog2(COLUMNS);
  localparam logic [KW-1:0]     LAST     = KW'(COLUMNS - 1);
  localparam logic [ADDR_W-1:0] ADDR_END = ADDR_W'(DEPTH - 1);
  localparam logic [6:0]        COL_LIM  = 7'(COLUMNS);
  localparam logic [6:0]        ROW_LIM  = 7'(ROWS);
  localparam logic [7:0]        PCOL_LIM = 8'(2 * COLUMNS);
  localparam logic [7:0]        PROW_LIM = 8'(2 * ROWS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_RDW   = 4'd3;
  localparam logic [3:0] S_POKE  = 4'd4;
  localparam logic [3:0] S_SH_RD = 4'd5;
  localparam logic [3:0] S_SH_WR = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;

  logic [3:0]        state;
  logic [2:0]        op;
  logic [KW-1:0]     k;
  logic [KW-1:0]     cstart;
  logic [ADDR_W-1:0] row_base;
  logic [ADDR_W-1:0] clr_addr;
  logic              clr_report;
  logic [7:0]        fill8;
  logic [7:0]        val;
  logic [7:0]        res;
  logic [3:0]        bit_sel;
  logic [1:0]        mode;

  logic              mem_re;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_rdata;

  logic              accept;
  logic              cell_ok;
  logic              plot_ok;
  logic [5:0]        col_eff;
  logic [5:0]        row_eff;
  logic              ins;
  logic              more;
  logic [KW-1:0]     k_prev;
  logic [KW-1:0]     k_succ;
  logic [ADDR_W-1:0] cur_addr;
  logic              out_load;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign cell_ok  = ({1'b0, col} < COL_LIM) && ({1'b0, row} < ROW_LIM);
  assign plot_ok  = ({2'b0, col} < PCOL_LIM) && ({2'b0, row} < PROW_LIM);
  assign col_eff  = (opcode == OP_PLOT) ? {1'b0, col[5:1]} : col;
  assign row_eff  = (opcode == OP_PLOT) ? {1'b0, row[5:1]} : row;
  assign ins      = (op == OP_INSERT);
  assign more     = ins ? (k > cstart) : (k != LAST);
  assign k_prev   = k - KW'(1);
  assign k_succ   = k + KW'(1);
  assign cur_addr = row_base + ADDR_W'(k);
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  always_comb begin
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = cur_addr;
    mem_wdata = 8'd0;
    case (state)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_addr;
      end
      S_RD: mem_re = 1'b1;
      S_RDW: begin
        if (op == OP_PLOT) begin
          mem_we    = 1'b1;
          mem_wdata = plot_code(mem_rdata, bit_sel, mode);
        end
      end
      S_POKE: begin
        mem_we    = 1'b1;
        mem_wdata = val;
      end
      S_SH_RD: begin
        if (more) begin
          mem_re   = 1'b1;
          mem_addr = row_base + ADDR_W'(ins ? k_prev : k_succ);
        end else begin
          mem_we    = 1'b1;
          mem_wdata = fill8;
        end
      end
      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
      end
      default: ;
    endcase
  end

  cce_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .re    (mem_re),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      clr_report <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid  <= 1'b1;
        read_value <= res;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op       <= opcode;
            k        <= (opcode == OP_INSERT) ? LAST : KW'(col_eff);
            cstart   <= KW'(col_eff);
            row_base <= ADDR_W'(32'(row_eff) * COLUMNS);
            fill8    <= graphics_fill ? GFX_FILL : 8'd0;
            val      <= write_value;
            mode     <= plot_mode;
            bit_sel  <= 4'd1 << {row[0], col[0]};
            res      <= (cell_ok && graphics_fill &&
                         (opcode == OP_INSERT || opcode == OP_DELETE)) ? GFX_FILL : 8'd0;
            case (opcode)
              OP_PEEK:   state <= cell_ok ? S_RD : S_OUT;
              OP_POKE:   state <= cell_ok ? S_POKE : S_OUT;
              OP_PLOT:   state <= plot_ok ? S_RD : S_OUT;
              OP_INSERT: state <= cell_ok ? S_SH_RD : S_OUT;
              OP_DELETE: state <= cell_ok ? S_SH_RD : S_OUT;
              OP_CLEAR: begin
                state      <= S_CLEAR;
                clr_addr   <= '0;
                clr_report <= 1'b1;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_END) begin
            state <= clr_report ? S_OUT : S_IDLE;
          end
        end
        S_RD: state <= S_RDW;
        S_RDW: begin
          res   <= (op == OP_PLOT) ? plot_code(mem_rdata, bit_sel, mode) : mem_rdata;
          state <= S_OUT;
        end
        S_POKE: begin
          res   <= val;
          state <= S_OUT;
        end
        S_SH_RD: state <= more ? S_SH_WR : S_OUT;
        S_SH_WR: begin
          if (!ins && k == cstart) res <= mem_rdata;
          k     <= ins ? k_prev : k_succ;
          state <= S_SH_RD;
        end
        S_OUT: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> state == S_CLEAR)
    else $error("reset did not start clearing pass");

  a_clear_writes_zero: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> mem_we && mem_wdata == 8'd0)
    else $error("clearing pass wrote nonzero data");

  a_shift_write_follows_read: assert property (@(posedge clk) disable iff (rst)
    state == S_SH_WR |-> $past(state) == S_SH_RD && $past(mem_re))
    else $error("shift write without preceding read");

  a_no_result_during_reset_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR && !clr_report |=> !$rose(out_valid))
    else $error("result produced by reset clearing pass");

endmodule
